>>> rtl/ccap_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Charge channel answer parser: shared package
// Character codes, register indexes, status codes and the frame record that
// the line parser hands to the answer judge.
// ----------------------------------------------------------------------------
package ccap_pkg;

   // Line buffer limit: bytes past this count in one line are dropped.
   localparam int LINE_MAX   = 128;
   localparam int LINE_CNT_W = $clog2(LINE_MAX + 1);

   // Register port geometry.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register indexes.
   localparam logic [1:0] REG_ADDRESS     = 2'd0;
   localparam logic [1:0] REG_COMMAND     = 2'd1;
   localparam logic [1:0] REG_FAULT_LIMIT = 2'd2;

   // Character codes.
   localparam logic [7:0] CHAR_BANG  = 8'h21;
   localparam logic [7:0] CHAR_QUERY = 8'h3F;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_TWO   = 8'h32;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UE    = 8'h45;
   localparam logic [7:0] CHAR_UF    = 8'h46;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LF    = 8'h66;

   // Connector status codes.
   localparam logic [3:0] ST_AVAILABLE   = 4'd0;
   localparam logic [3:0] ST_PREPARING   = 4'd1;
   localparam logic [3:0] ST_CHARGING    = 4'd2;
   localparam logic [3:0] ST_SUSP_EVSE   = 4'd3;
   localparam logic [3:0] ST_SUSP_EV     = 4'd4;
   localparam logic [3:0] ST_FINISHING   = 4'd5;
   localparam logic [3:0] ST_UNAVAILABLE = 4'd7;
   localparam logic [3:0] ST_FAULTED     = 4'd8;

   // Pilot level and PWM codes.
   localparam logic [2:0] LEVEL_A = 3'd0;
   localparam logic [2:0] LEVEL_B = 3'd1;
   localparam logic [2:0] LEVEL_C = 3'd2;
   localparam logic [2:0] LEVEL_D = 3'd3;
   localparam logic [2:0] LEVEL_F = 3'd5;

   localparam logic [1:0] PWM_NONE    = 2'd0;
   localparam logic [1:0] PWM_UNKNOWN = 2'd3;

   // Meter saturation bounds.
   localparam logic [31:0] METER_SAT = 32'h8000_0000;
   localparam logic [31:0] METER_MAX = 32'h7FFF_FFFF;

   // Miss counter ceiling.
   localparam logic [3:0] MISS_MAX = 4'd15;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_STATUS,
      CMD_START,
      CMD_HALT,
      CMD_METER,
      CMD_PILOT,
      CMD_UNLOCK,
      CMD_LOCK_QUERY
   } cmd_type;

   typedef enum logic [1:0] {
      PH_WAIT,
      PH_ADDR_HI,
      PH_ADDR_LO,
      PH_PAYLOAD
   } phase_type;

   typedef struct packed {
      logic neg;
      logic bad;
      logic dig;
   } num_flags_type;

   // Frame record of the line received so far.
   typedef struct packed {
      phase_type     phase;
      logic          start_err;
      logic [7:0]    addr;
      logic          hdr_ok;
      logic [1:0]    pay_cnt;
      logic [7:0]    first;
      logic [7:0]    second;
      logic [31:0]   num;
      num_flags_type flags;
   } frame_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   // Decode one hex character, upper or lower case.
   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.ok  = 1'b1;
      h.val = 4'd0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         h.val = 4'(c - CHAR_ZERO);
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
         h.val = 4'(c - CHAR_UA + 8'd10);
      end else if (c >= CHAR_LA && c <= CHAR_LF) begin
         h.val = 4'(c - CHAR_LA + 8'd10);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

endpackage
`default_nettype wire

>>> rtl/ccap_frame.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Charge channel answer parser: line framer
// Tracks the start character, the two address characters and the payload of
// the current line, including the saturating decimal accumulator.
// ----------------------------------------------------------------------------
module ccap_frame
   import ccap_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       byte_go,
   input  wire logic [7:0] byte_data,
   output frame_type       frame
);

   logic [LINE_CNT_W-1:0] line_cnt_ff, line_cnt_in;
   frame_type             frame_ff, frame_in;

   hex_type     hex;
   logic [3:0]  digit;
   logic [35:0] num_x10;
   logic        is_digit;

   assign hex      = hex_decode(byte_data);
   assign is_digit = (byte_data >= CHAR_ZERO) && (byte_data <= CHAR_NINE);
   assign digit    = 4'(byte_data - CHAR_ZERO);

   // Decimal accumulate: times ten plus the new digit.
   assign num_x10 = ({4'd0, frame_ff.num} << 3) + ({4'd0, frame_ff.num} << 1)
                  + {32'd0, digit};

   // Next frame state for one received byte.
   always_comb begin
      line_cnt_in = line_cnt_ff;
      frame_in    = frame_ff;
      if (byte_go) begin
         if (byte_data == CHAR_CR) begin
            line_cnt_in = '0;
            frame_in    = '0;
         end else if (line_cnt_ff < LINE_CNT_W'(LINE_MAX)) begin
            line_cnt_in = line_cnt_ff + 1'b1;
            if (byte_data == CHAR_BANG || byte_data == CHAR_QUERY) begin
               frame_in           = '0;
               frame_in.phase     = PH_ADDR_HI;
               frame_in.start_err = (byte_data == CHAR_QUERY);
               frame_in.hdr_ok    = 1'b1;
            end else begin
               unique case (frame_ff.phase)
                  PH_WAIT: begin
                  end
                  PH_ADDR_HI: begin
                     if (!hex.ok) begin
                        frame_in.hdr_ok = 1'b0;
                     end else begin
                        frame_in.addr = {hex.val, 4'h0};
                     end
                     frame_in.phase = PH_ADDR_LO;
                  end
                  PH_ADDR_LO: begin
                     if (!hex.ok) begin
                        frame_in.hdr_ok = 1'b0;
                     end else begin
                        frame_in.addr[3:0] = hex.val;
                     end
                     frame_in.phase = PH_PAYLOAD;
                  end
                  PH_PAYLOAD: begin
                     if (frame_ff.pay_cnt == 2'd0) begin
                        frame_in.first = byte_data;
                     end else if (frame_ff.pay_cnt == 2'd1) begin
                        frame_in.second = byte_data;
                     end
                     if (frame_ff.pay_cnt == 2'd0 &&
                         (byte_data == CHAR_MINUS || byte_data == CHAR_PLUS)) begin
                        if (byte_data == CHAR_MINUS) begin
                           frame_in.flags.neg = 1'b1;
                        end
                     end else if (is_digit) begin
                        if (num_x10 > {4'd0, METER_SAT}) begin
                           frame_in.num = METER_SAT;
                        end else begin
                           frame_in.num = num_x10[31:0];
                        end
                        frame_in.flags.dig = 1'b1;
                     end else begin
                        frame_in.flags.bad = 1'b1;
                     end
                     // The count only needs to tell zero, one, two and more apart.
                     if (frame_ff.pay_cnt != 2'd3) begin
                        frame_in.pay_cnt = frame_ff.pay_cnt + 2'd1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_cnt_ff <= '0;
         frame_ff    <= '0;
      end else begin
         line_cnt_ff <= line_cnt_in;
         frame_ff    <= frame_in;
      end
   end

   assign frame = frame_ff;

`ifndef SYNTH
   // The line counter never runs past the buffer limit.
   assert property (@(posedge clock) disable iff (reset)
      line_cnt_ff <= LINE_CNT_W'(LINE_MAX))
      else $error("line counter past limit");

   // Outside a frame the header is never marked good.
   assert property (@(posedge clock) disable iff (reset)
      frame_ff.phase == PH_WAIT |-> !frame_ff.hdr_ok)
      else $error("header good outside a frame");

   // Payload characters are only counted in the payload phase.
   assert property (@(posedge clock) disable iff (reset)
      frame_ff.phase != PH_PAYLOAD |-> frame_ff.pay_cnt == 2'd0)
      else $error("payload counted outside the payload phase");
`endif

endmodule
`default_nettype wire

>>> rtl/charge_channel_answer_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Charge channel answer parser
// Parses answer lines from a charging channel controller and keeps the
// connector status, pilot, lock and meter state.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_valid / req_stall): one transfer per received byte
//    (req_type 0) or per missed pilot poll (req_type 1).
//  - Result channel (rsp_valid / rsp_stall): one transfer for each carriage
//    return or missed-poll tick; other bytes give no result.
//  - Register port: connector address at 0x0, pending command at 0x4 and
//    fault limit at 0x8; pready is always high.
//  - A request transfer is held in the input register; its result is then
//    held in the result register until the result transfer.
//  - Throughput is one item per cycle while no result waits on a stall; each
//    item is one pass of logic from the input to the result register.
//  - While the receiver stalls a waiting result, bytes that give no result
//    still pass; an item that gives a result waits in the input register,
//    and req_stall rises only when that register is held.
//  - Reset clears the line, status unavailable, pilot level F, PWM unknown,
//    lock set, meter zero, offline; fault limit returns to five.
// ----------------------------------------------------------------------------
module charge_channel_answer_parser_core
   import ccap_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_type,
   input  wire logic [7:0]            req_rx_byte,
   // Result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_answer_ok,
   output logic [3:0]                 rsp_conn_status,
   output logic [2:0]                 rsp_pilot_level,
   output logic [1:0]                 rsp_pilot_pwm,
   output logic                       rsp_locked,
   output logic signed [31:0]         rsp_meter_value,
   output logic                       rsp_meter_is_error,
   output logic                       rsp_status_changed,
   output logic                       rsp_online,
   output logic                       rsp_faulted,
   // Register port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   // Configuration registers
   logic [7:0] cfg_addr_ff;
   cmd_type    cfg_cmd_ff;
   logic [3:0] cfg_limit_ff;
   logic       csr_write;

   // Input register
   logic       s1_valid_ff;
   logic       s1_type_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_emits;
   logic       s1_go;
   logic       out_free;
   logic       req_take;

   // Connector state
   logic [3:0]  status_ff, status_in;
   logic [2:0]  level_ff, level_in;
   logic [1:0]  pwm_ff, pwm_in;
   logic        lock_ff, lock_in;
   logic [31:0] meter_ff, meter_in;
   logic        meter_err_ff, meter_err_in;
   logic [3:0]  miss_ff, miss_in;
   logic        online_ff, online_in;
   logic        ok_in;
   logic        flt_in;

   // Result register
   logic        rsp_valid_ff;
   logic        rsp_ok_ff;
   logic [3:0]  rsp_status_ff;
   logic [2:0]  rsp_level_ff;
   logic [1:0]  rsp_pwm_ff;
   logic        rsp_lock_ff;
   logic [31:0] rsp_meter_ff;
   logic        rsp_meter_err_ff;
   logic        rsp_changed_ff;
   logic        rsp_online_ff;
   logic        rsp_faulted_ff;

   frame_type   frame;
   hex_type     status_hex;
   logic        frame_match;

   // Register port: writes complete in the access phase.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_addr_ff  <= 8'd0;
         cfg_cmd_ff   <= CMD_NONE;
         cfg_limit_ff <= 4'd5;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_ADDRESS:     cfg_addr_ff  <= csr_pwdata[7:0];
            REG_COMMAND:     cfg_cmd_ff   <= cmd_type'(csr_pwdata[2:0]);
            REG_FAULT_LIMIT: cfg_limit_ff <= csr_pwdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_ADDRESS:     csr_prdata = {24'd0, cfg_addr_ff};
         REG_COMMAND:     csr_prdata = {29'd0, cfg_cmd_ff};
         REG_FAULT_LIMIT: csr_prdata = {28'd0, cfg_limit_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // Input register and flow control.
   assign s1_emits  = s1_type_ff || (s1_byte_ff == CHAR_CR);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_go     = s1_valid_ff && (!s1_emits || out_free);
   assign req_stall = s1_valid_ff && !s1_go;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_take || (s1_valid_ff && !s1_go);
      end
      if (req_take) begin
         s1_type_ff <= req_type;
         s1_byte_ff <= req_rx_byte;
      end
   end

   // Line framer sees every received byte that moves on.
   ccap_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .byte_go   (s1_go && !s1_type_ff),
      .byte_data (s1_byte_ff),
      .frame     (frame)
   );

   assign status_hex  = hex_decode(frame.first);
   assign frame_match = (frame.phase == PH_PAYLOAD) && frame.hdr_ok
                     && (frame.addr == cfg_addr_ff);

   // Judge the line at a carriage return, or count a missed poll.
   always_comb begin
      logic [2:0] lv;
      logic [1:0] pw;
      logic [3:0] ns;
      logic       keep;

      status_in    = status_ff;
      level_in     = level_ff;
      pwm_in       = pwm_ff;
      lock_in      = lock_ff;
      meter_in     = meter_ff;
      meter_err_in = meter_err_ff;
      miss_in      = miss_ff;
      online_in    = online_ff;
      ok_in        = 1'b0;
      flt_in       = 1'b0;

      lv   = (frame.first >= CHAR_UA && frame.first <= CHAR_UE)
           ? 3'(frame.first - CHAR_UA) : LEVEL_F;
      pw   = (frame.second >= CHAR_ZERO && frame.second <= CHAR_TWO)
           ? 2'(frame.second - CHAR_ZERO) : PWM_UNKNOWN;
      ns   = ST_AVAILABLE;
      keep = 1'b1;

      if (s1_type_ff) begin
         if (miss_ff != MISS_MAX) begin
            miss_in = miss_ff + 4'd1;
         end
         if (miss_in >= cfg_limit_ff) begin
            status_in = ST_FAULTED;
            level_in  = LEVEL_F;
            pwm_in    = PWM_UNKNOWN;
            online_in = 1'b0;
            flt_in    = 1'b1;
         end
      end else if (frame_match) begin
         unique case (cfg_cmd_ff)
            CMD_STATUS: begin
               if (frame.pay_cnt != 2'd0 && status_hex.ok) begin
                  status_in = status_hex.val;
                  ok_in     = 1'b1;
               end
            end
            CMD_PILOT: begin
               if (frame.pay_cnt >= 2'd2) begin
                  // Connector state machine runs only when the pilot changes.
                  if (lv != level_ff || pw != pwm_ff) begin
                     priority if (lv == LEVEL_A) begin
                        ns   = ST_AVAILABLE;
                        keep = 1'b0;
                     end else if (lv == LEVEL_B) begin
                        priority if (status_ff == ST_AVAILABLE) begin
                           ns   = ST_PREPARING;
                           keep = 1'b0;
                        end else if (pw == PWM_NONE) begin
                           if (status_ff != ST_FINISHING) begin
                              ns   = ST_SUSP_EVSE;
                              keep = 1'b0;
                           end
                        end else if (pw != PWM_UNKNOWN) begin
                           ns   = ST_SUSP_EV;
                           keep = 1'b0;
                        end else begin
                           // An unknown PWM keeps the status.
                        end
                     end else if (lv == LEVEL_C || lv == LEVEL_D) begin
                        if (pw != PWM_NONE) begin
                           ns   = ST_CHARGING;
                           keep = 1'b0;
                        end
                     end else begin
                        // Levels E and F keep the status.
                     end
                     if (!keep) begin
                        status_in = ns;
                     end
                     level_in = lv;
                     pwm_in   = pw;
                  end
                  miss_in   = 4'd0;
                  online_in = 1'b1;
                  ok_in     = 1'b1;
               end
            end
            CMD_START, CMD_HALT: begin
               ok_in = !frame.start_err;
            end
            CMD_METER: begin
               if (!frame.flags.bad && frame.flags.dig) begin
                  if (frame.flags.neg) begin
                     meter_in = 32'd0 - frame.num;
                  end else if (frame.num > METER_MAX) begin
                     meter_in = METER_MAX;
                  end else begin
                     meter_in = frame.num;
                  end
                  meter_err_in = frame.start_err;
                  ok_in        = 1'b1;
               end
            end
            CMD_UNLOCK: begin
               lock_in = frame.start_err;
               ok_in   = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // Connector state updates only for items that give a result.
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff    <= ST_UNAVAILABLE;
         level_ff     <= LEVEL_F;
         pwm_ff       <= PWM_UNKNOWN;
         lock_ff      <= 1'b1;
         meter_ff     <= 32'd0;
         meter_err_ff <= 1'b0;
         miss_ff      <= 4'd0;
         online_ff    <= 1'b0;
      end else if (s1_go && s1_emits) begin
         status_ff    <= status_in;
         level_ff     <= level_in;
         pwm_ff       <= pwm_in;
         lock_ff      <= lock_in;
         meter_ff     <= meter_in;
         meter_err_ff <= meter_err_in;
         miss_ff      <= miss_in;
         online_ff    <= online_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go && s1_emits) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s1_go && s1_emits) begin
         rsp_ok_ff        <= ok_in;
         rsp_status_ff    <= status_in;
         rsp_level_ff     <= level_in;
         rsp_pwm_ff       <= pwm_in;
         rsp_lock_ff      <= lock_in;
         rsp_meter_ff     <= meter_in;
         rsp_meter_err_ff <= meter_err_in;
         rsp_changed_ff   <= (status_in != status_ff);
         rsp_online_ff    <= online_in;
         rsp_faulted_ff   <= flt_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_answer_ok      = rsp_ok_ff;
   assign rsp_conn_status    = rsp_status_ff;
   assign rsp_pilot_level    = rsp_level_ff;
   assign rsp_pilot_pwm      = rsp_pwm_ff;
   assign rsp_locked         = rsp_lock_ff;
   assign rsp_meter_value    = $signed(rsp_meter_ff);
   assign rsp_meter_is_error = rsp_meter_err_ff;
   assign rsp_status_changed = rsp_changed_ff;
   assign rsp_online         = rsp_online_ff;
   assign rsp_faulted        = rsp_faulted_ff;

`ifndef SYNTH
   // A fault result is never also a good answer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_faulted_ff |-> !rsp_ok_ff)
      else $error("faulted result marked as good answer");

   // A fault result shows the faulted status and an offline connector.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_faulted_ff |-> rsp_status_ff == ST_FAULTED && !rsp_online_ff)
      else $error("faulted result with wrong status");

   // The request side is held back only while the input register is full.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("stall with empty input register");

   // An item that gives a result shows up on the result channel next cycle.
   assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_emits |=> rsp_valid_ff)
      else $error("result lost");
`endif

endmodule
`default_nettype wire
